### hdl/xfc_pkg.sv
// constants and types shared by the xor frame checker
// no dependencies; imported by xor_frame_checker_core
`default_nettype none
package xfc_pkg;

	localparam int MAX_PAYLOAD = 62;
	localparam int BUF_DEPTH   = 64;
	localparam int BUF_AW      = $clog2(BUF_DEPTH);
	localparam int CNT_W       = 7;
	localparam int LEN_W       = 6;

	localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
	localparam logic [7:0]       LEN_MASK = 8'h3f;

	localparam int ENDFILE_BIT = 7;
	localparam int CONNECT_BIT = 6;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_LEN  = 2'd1;
	localparam logic [1:0] STAT_CSUM = 2'd2;

	localparam logic KIND_STATUS  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STAT,
		ST_RD,
		ST_PAY
	} state_t;

endpackage
`default_nettype wire

### hdl/xor_frame_checker_core.sv
// xor frame checker: checksum / length check of framed bytes with payload replay
// depends on xfc_pkg
//
// Usage: frame bytes enter on the rx channel (rx_valid, rx_stall, rx_byte,
// frame_end), header first and checksum last, frame_end set on the checksum.
// Results leave on the res channel (res_valid, res_stall and the result
// fields). A byte without frame_end is absorbed and gives no result. The
// checksum byte gives one status result, loaded into the output register
// from the ST_STAT state; an accepted data frame then replays its payload,
// one byte at a time from a 64 x 8 staging memory via a registered port.
// Each payload byte is read in ST_RD and loaded in ST_PAY before the next
// byte is read. rx_stall is high from the checksum transfer until the last
// result of the frame is loaded into the output register.
// When the receiver holds res_stall, the output register keeps its result
// and the sequencer waits; nothing is dropped.
// Reset clears the sequencer, running checksum, byte count, flags and the
// accepted frame counter; the staging memory is not cleared.
`default_nettype none
module xor_frame_checker_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       rx_valid,
	output logic                            rx_stall,
	input  wire logic [7:0]                 rx_byte,
	input  wire logic                       frame_end,
	output logic                            res_valid,
	input  wire logic                       res_stall,
	output logic                            kind,
	output logic [1:0]                      status,
	output logic                            stored,
	output logic [7:0]                      frame_count,
	output logic [xfc_pkg::LEN_W-1:0]       payload_length,
	output logic [7:0]                      payload_byte,
	output logic                            run_last
);
	import xfc_pkg::*;

	state_t state_q, state_d;

	logic [7:0]        xor_q;
	logic [CNT_W-1:0]  count_q;
	logic              overlen_q;
	logic [7:0]        header_q;
	logic [7:0]        accepted_q;

	logic [1:0]        pend_status_q;
	logic              pend_stored_q;
	logic [LEN_W-1:0]  len_q;

	logic [BUF_AW-1:0] rd_idx_q;
	logic [7:0]        rd_data_q;
	logic [7:0]        buf_mem [BUF_DEPTH];

	logic              out_valid_q;
	logic              kind_q, stored_q, run_last_q;
	logic [1:0]        status_q;
	logic [7:0]        frame_count_q, payload_byte_q;
	logic [LEN_W-1:0]  payload_length_q;

	logic              rx_xfer, take_byte, take_end;
	logic              out_free, load_status, load_pay, pay_last;
	logic [7:0]        hdr;
	logic [LEN_W-1:0]  datlen;
	logic [CNT_W-1:0]  count_m1;
	logic [1:0]        end_status;
	logic              end_data;
	logic              mem_we;

	assign rx_stall  = (state_q != ST_IDLE);
	assign rx_xfer   = rx_valid && !rx_stall;
	assign take_byte = rx_xfer && !frame_end;
	assign take_end  = rx_xfer && frame_end;
	assign out_free  = !out_valid_q || !res_stall;

	assign count_m1 = count_q - CNT_W'(1);
	assign mem_we   = take_byte && (count_q != '0) && (count_q <= CNT_W'(BUF_DEPTH));

	// frame end checks, in priority order
	always_comb begin
		hdr    = (count_q == '0) ? rx_byte : header_q;
		datlen = LEN_W'(hdr & LEN_MASK);
		if (overlen_q || (count_q > CNT_W'(MAX_PAYLOAD + 1)))
			end_status = STAT_LEN;
		else if (xor_q != rx_byte)
			end_status = STAT_CSUM;
		else if ((count_q == '0) || ({1'b0, datlen} != count_m1))
			end_status = STAT_LEN;
		else
			end_status = STAT_OK;
		end_data = (end_status == STAT_OK) && hdr[ENDFILE_BIT] && !hdr[CONNECT_BIT];
	end

	assign pay_last = ({1'b0, rd_idx_q} + 7'd1) == {1'b0, len_q};

	// sequencer: status result, then read / present per payload byte
	always_comb begin
		state_d     = state_q;
		load_status = 1'b0;
		load_pay    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (take_end)
					state_d = ST_STAT;
			end
			ST_STAT: begin
				if (out_free) begin
					load_status = 1'b1;
					if (pend_stored_q && (len_q != '0))
						state_d = ST_RD;
					else
						state_d = ST_IDLE;
				end
			end
			ST_RD: begin
				state_d = ST_PAY;
			end
			ST_PAY: begin
				if (out_free) begin
					load_pay = 1'b1;
					state_d  = pay_last ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// frame accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q      <= '0;
			count_q    <= '0;
			overlen_q  <= 1'b0;
			header_q   <= '0;
			accepted_q <= '0;
		end else if (take_byte) begin
			if (count_q == '0)
				header_q <= rx_byte;
			xor_q <= xor_q ^ rx_byte;
			if (count_q != CNT_MAX)
				count_q <= count_q + CNT_W'(1);
			if (count_q >= CNT_W'(MAX_PAYLOAD + 1))
				overlen_q <= 1'b1;
		end else if (take_end) begin
			xor_q     <= '0;
			count_q   <= '0;
			overlen_q <= 1'b0;
			header_q  <= '0;
			if (end_data)
				accepted_q <= accepted_q + 8'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_end) begin
			pend_status_q <= end_status;
			pend_stored_q <= end_data;
			len_q         <= datlen;
		end
	end

	// staging memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			buf_mem[count_m1[BUF_AW-1:0]] <= rx_byte;
		rd_data_q <= buf_mem[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (load_status)
			rd_idx_q <= '0;
		else if (load_pay)
			rd_idx_q <= rd_idx_q + BUF_AW'(1);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_status || load_pay)
			out_valid_q <= 1'b1;
		else if (!res_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_status) begin
			kind_q           <= KIND_STATUS;
			status_q         <= pend_status_q;
			stored_q         <= pend_stored_q;
			frame_count_q    <= accepted_q;
			payload_length_q <= len_q;
			payload_byte_q   <= '0;
			run_last_q       <= !(pend_stored_q && (len_q != '0));
		end else if (load_pay) begin
			kind_q           <= KIND_PAYLOAD;
			status_q         <= STAT_OK;
			stored_q         <= 1'b1;
			frame_count_q    <= accepted_q;
			payload_length_q <= len_q;
			payload_byte_q   <= rd_data_q;
			run_last_q       <= pay_last;
		end
	end

	assign res_valid      = out_valid_q;
	assign kind           = kind_q;
	assign status         = status_q;
	assign stored         = stored_q;
	assign frame_count    = frame_count_q;
	assign payload_length = payload_length_q;
	assign payload_byte   = payload_byte_q;
	assign run_last       = run_last_q;

`ifndef NO_ASSERTIONS
	// payload results only belong to accepted data frames
	a_pay_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (kind_q == KIND_PAYLOAD)) |-> (stored_q && (status_q == STAT_OK)))
		else $error("payload result outside an accepted frame");

	// overlength flag implies the count ran past the limit
	a_overlen_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		overlen_q |-> (count_q > CNT_W'(MAX_PAYLOAD + 1)))
		else $error("overlength flag without long count");

	// replay only runs for a nonempty payload
	a_replay_len: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RD) || (state_q == ST_PAY)) |-> (len_q != '0))
		else $error("replay with zero payload length");

	// a result that is not the last of its frame means the sequencer is still busy
	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !run_last_q) |-> (state_q != ST_IDLE))
		else $error("sequencer idle before last result");
`endif

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for xor_frame_checker_core: drives framed bytes, predicts status and replay
// depends on xfc_pkg and the xor_frame_checker_core rtl
module tb_top;
	import xfc_pkg::*;

	localparam int LIMIT = 400000;

	typedef struct {
		logic [7:0] val;
		logic       fin;
	} rx_item_t;

	typedef struct {
		logic             kind;
		logic [1:0]       status;
		logic             stored;
		logic [7:0]       frame_count;
		logic [LEN_W-1:0] payload_length;
		logic [7:0]       payload_byte;
		logic             run_last;
	} frame_result_t;

	typedef enum int {
		FR_DATA,
		FR_PLAIN,
		FR_BADSUM,
		FR_BADLEN,
		FR_SHORT,
		FR_LONG
	} frame_shape_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_valid = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic frame_end = 1'b0;
	logic res_stall = 1'b0;
	wire logic rx_stall;
	wire logic res_valid;
	wire logic kind;
	wire logic [1:0] status;
	wire logic stored;
	wire logic [7:0] frame_count;
	wire logic [LEN_W-1:0] payload_length;
	wire logic [7:0] payload_byte;
	wire logic run_last;

	rx_item_t rx_pending[$];
	rx_item_t next_item;
	frame_result_t frame_outcomes[$];
	frame_result_t want;
	frame_result_t got;

	// shadow of the checker state
	logic [7:0]       xor_seen = 8'h00;
	logic [CNT_W-1:0] cnt_seen = '0;
	logic             too_long = 1'b0;
	logic [7:0]       hdr_seen = 8'h00;
	logic [7:0]       stage[BUF_DEPTH];
	logic [7:0]       frames_ok = 8'h00;

	int items_sent = 0;
	int n_items = 0;
	int cycles = 0;
	int mismatches = 0;
	int n_status = 0;
	int n_payload = 0;
	int data_frames = 0;

	// no idling on either side for a stretch in the middle of the run
	wire calm = items_sent >= 150 && items_sent < 400;

	xor_frame_checker_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_valid),
		.rx_stall       (rx_stall),
		.rx_byte        (rx_byte),
		.frame_end      (frame_end),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.kind           (kind),
		.status         (status),
		.stored         (stored),
		.frame_count    (frame_count),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.run_last       (run_last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic absorb_byte(input logic [7:0] b, input logic fin);
		int total;
		logic [7:0] hdr;
		logic [LEN_W-1:0] plen;
		logic [1:0] st;
		frame_result_t r;
		if (!fin) begin
			if (cnt_seen == 0)
				hdr_seen = b;
			else if (int'(cnt_seen) - 1 < BUF_DEPTH)
				stage[int'(cnt_seen) - 1] = b;
			xor_seen ^= b;
			if (cnt_seen != CNT_MAX)
				cnt_seen++;
			if (cnt_seen > MAX_PAYLOAD + 1)
				too_long = 1'b1;
			return;
		end
		// checksum byte; on a one-byte frame it is the header as well
		total = int'(cnt_seen) + 1;
		hdr = (cnt_seen == 0) ? b : hdr_seen;
		plen = hdr[LEN_W-1:0];
		if (too_long || total > MAX_PAYLOAD + 2)
			st = STAT_LEN;
		else if (xor_seen != b)
			st = STAT_CSUM;
		else if (total < 2 || int'(plen) != total - 2)
			st = STAT_LEN;
		else
			st = STAT_OK;
		r = '{KIND_STATUS, st, 1'b0, frames_ok, plen, 8'h00, 1'b1};
		if (st == STAT_OK && hdr[ENDFILE_BIT] && !hdr[CONNECT_BIT]) begin
			frames_ok++;
			data_frames++;
			r.stored = 1'b1;
			r.frame_count = frames_ok;
			r.run_last = (plen == 0);
			frame_outcomes.push_back(r);
			for (int i = 0; i < plen; i++) begin
				r.kind = KIND_PAYLOAD;
				r.payload_byte = stage[i];
				r.run_last = (i == plen - 1);
				frame_outcomes.push_back(r);
			end
		end else begin
			frame_outcomes.push_back(r);
		end
		xor_seen = 8'h00;
		cnt_seen = '0;
		too_long = 1'b0;
		hdr_seen = 8'h00;
	endtask

	task automatic push_item(input logic [7:0] val, input logic fin);
		rx_item_t it;
		it.val = val;
		it.fin = fin;
		rx_pending.push_back(it);
	endtask

	// header, npay random payload bytes, then the xor checksum with the bits set in flip inverted
	task automatic make_frame(input logic [7:0] hdr, input int npay, input logic [7:0] flip);
		logic [7:0] sum;
		logic [7:0] b;
		sum = hdr;
		push_item(hdr, 1'b0);
		repeat (npay) begin
			b = 8'($urandom);
			sum ^= b;
			push_item(b, 1'b0);
		end
		push_item(sum ^ flip, 1'b1);
	endtask

	// driver: next byte only once the current one has been taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
			rx_byte <= 8'h00;
			frame_end <= 1'b0;
		end else begin
			if (rx_valid && !rx_stall)
				items_sent <= items_sent + 1;
			if (!rx_valid || !rx_stall) begin
				if (rx_pending.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
					next_item = rx_pending.pop_front();
					rx_valid <= 1'b1;
					rx_byte <= next_item.val;
					frame_end <= next_item.fin;
				end else begin
					rx_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transfer, then folds any accepted byte into the shadow state
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				got = '{kind, status, stored, frame_count, payload_length, payload_byte,
					run_last};
				if (frame_outcomes.size() == 0) begin
					$error("result transfer with nothing outstanding: kind %0d", got.kind);
					mismatches++;
				end else begin
					want = frame_outcomes.pop_front();
					if (want.kind == KIND_STATUS)
						n_status++;
					else
						n_payload++;
					if (got.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, got.kind);
						mismatches++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						mismatches++;
					end
					if (got.stored !== want.stored) begin
						$error("stored: expected %0d, got %0d", want.stored, got.stored);
						mismatches++;
					end
					if (got.frame_count !== want.frame_count) begin
						$error("frame_count: expected %0d, got %0d", want.frame_count,
							got.frame_count);
						mismatches++;
					end
					if (got.payload_length !== want.payload_length) begin
						$error("payload_length: expected %0d, got %0d", want.payload_length,
							got.payload_length);
						mismatches++;
					end
					if (got.payload_byte !== want.payload_byte) begin
						$error("payload_byte: expected %0d, got %0d", want.payload_byte,
							got.payload_byte);
						mismatches++;
					end
					if (got.run_last !== want.run_last) begin
						$error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
						mismatches++;
					end
				end
			end
			if (rx_valid && !rx_stall)
				absorb_byte(rx_byte, frame_end);
			res_stall <= !calm && ($urandom_range(99) < 6);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		frame_shape_t shape;
		int r;
		int len;
		int npay;
		logic [1:0] top;

		// directed: single-byte frames, empty and short data frames, non-data and broken frames
		push_item(8'h00, 1'b1);
		push_item(8'hff, 1'b1);
		make_frame(8'h80, 0, 8'h00);
		make_frame(8'h83, 3, 8'h00);
		make_frame(8'hc2, 2, 8'h00);
		make_frame(8'h02, 2, 8'h00);
		make_frame(8'h81, 1, 8'h5a);
		make_frame(8'h84, 2, 8'h00);
		// longest payload, one byte over the limit, and a frame long enough to saturate the count
		make_frame(8'hbe, MAX_PAYLOAD, 8'h00);
		make_frame(8'hbf, MAX_PAYLOAD + 1, 8'h00);
		make_frame(8'($urandom), 130, 8'h00);

		// random frames fill the run up to about 450 bytes
		while (rx_pending.size() < 450) begin
			r = $urandom_range(99);
			if (r < 70)      shape = FR_DATA;
			else if (r < 80) shape = FR_PLAIN;
			else if (r < 88) shape = FR_BADSUM;
			else if (r < 95) shape = FR_BADLEN;
			else if (r < 98) shape = FR_SHORT;
			else             shape = FR_LONG;
			case (shape)
				FR_DATA: begin
					len = ($urandom_range(19) == 0) ? $urandom_range(30, MAX_PAYLOAD)
						: $urandom_range(0, 8);
					make_frame({2'b10, 6'(len)}, len, 8'h00);
				end
				FR_PLAIN: begin
					len = $urandom_range(0, 6);
					r = $urandom_range(2);
					top = (r == 0) ? 2'b00 : (r == 1) ? 2'b01 : 2'b11;
					make_frame({top, 6'(len)}, len, 8'h00);
				end
				FR_BADSUM: begin
					len = $urandom_range(0, 6);
					make_frame({2'b10, 6'(len)}, len, 8'($urandom_range(1, 255)));
				end
				FR_BADLEN: begin
					len = $urandom_range(0, 6);
					npay = $urandom_range(0, 8);
					if (npay == len)
						npay = len + 1 + $urandom_range(0, 2);
					make_frame({2'($urandom), 6'(len)}, npay, 8'h00);
				end
				FR_SHORT: push_item(8'($urandom), 1'b1);
				FR_LONG: make_frame(8'($urandom), $urandom_range(MAX_PAYLOAD + 1, 70), 8'h00);
				default: ;
			endcase
		end
		n_items = rx_pending.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (items_sent != n_items)
			@(posedge clk);
		while (frame_outcomes.size() != 0)
			@(posedge clk);
		// room for any stray result after the last frame
		repeat (2 * BUF_DEPTH + 16) @(posedge clk);

		$display("%0d bytes sent in frames of every shape, %0d data frames accepted", items_sent,
			data_frames);
		$display("%0d status and %0d payload results compared", n_status, n_payload);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
